FILE: hdl/bitmap_frame_allocator_assert.svh
// ----------------------------------------------------------------------------
// bitmap frame allocator assertion macros
// Property macros shared by the allocator modules; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define BFA_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfa assertion failed");
// next-cycle implication, checked out of reset
`define BFA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfa assertion failed");
`else
`define BFA_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define BFA_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Types, codes and helper functions of the bitmap frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

    // bitmap geometry
    localparam int unsigned MAX_FRAMES = 65536;
    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned WORD_COUNT = MAX_FRAMES / WORD_BITS;
    localparam int unsigned ADDR_W     = $clog2(WORD_COUNT);
    localparam int unsigned BIT_W      = $clog2(WORD_BITS);
    localparam int unsigned CNT_W      = BIT_W + 1;

    // field widths
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned FRAME_W = 16;
    localparam int unsigned COUNT_W = 17;

    typedef logic [WORD_BITS-1:0] word_t;

    // request codes
    localparam logic [FUNC_W-1:0] FN_ALLOC   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FREE    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_RESERVE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REPORT  = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FRAME_W-1:0] base_frame;
        logic [COUNT_W-1:0] frame_count;
    } req_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_number;
        logic               granted;
        logic [COUNT_W-1:0] free_count;
        logic [COUNT_W-1:0] run_length;
        logic               run_taken;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic fill;
        logic cfg_load;
        logic load_req;
        logic rd;
        logic eval;
        logic step;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic              fill_last;
        logic              no_work;
        logic              at_last;
        logic              hit;
        logic [FUNC_W-1:0] func;
    } stat_t;

    // position of the lowest set bit, zero when none
    function automatic logic [BIT_W-1:0] lowest_one(input word_t w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

    // number of set bits, summed per byte
    function automatic logic [CNT_W-1:0] count_ones(input word_t w);
        logic [3:0]       part;
        logic [CNT_W-1:0] sum;
        sum = '0;
        for (int k = 0; k < WORD_BITS / 8; k++) begin
            part = '0;
            for (int j = 0; j < 8; j++) begin
                part = part + 4'(w[8*k+j]);
            end
            sum = sum + CNT_W'(part);
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer of the allocator: bitmap fill, word scan loop and handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_frame_allocator_assert.svh"

module bfa_ctrl
    import bfa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  wire logic  out_stall,
    input  wire logic  cfg_valid,
    output logic       cfg_ready,
    input  wire stat_t st,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cfg_ready  = (state_reg == ST_INIT) || (state_reg == ST_IDLE);
        in_stall   = (state_reg != ST_IDLE) || cfg_valid;

        case (state_reg)
            ST_INIT:
            begin
                if (cfg_valid)
                begin
                    cmd.cfg_load = 1'b1;
                end
                else
                begin
                    cmd.fill = 1'b1;
                    if (st.fill_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.cfg_load = 1'b1;
                    state_next   = ST_INIT;
                end
                else if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                if (st.no_work)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_FINISH;
                if (st.func == FN_ALLOC || st.func == FN_REPORT)
                begin
                    if (!st.hit && !st.at_last)
                    begin
                        cmd.step   = 1'b1;
                        state_next = ST_READ;
                    end
                end
                else if (st.func == FN_RESERVE || st.func == FN_RELEASE)
                begin
                    if (!st.at_last)
                    begin
                        cmd.step   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        // output word held until taken
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    `BFA_ASSERT_NEXT(a_accept_reads, clk, rst_n, in_valid && !in_stall, state_reg == ST_READ)
    `BFA_ASSERT_NEXT(a_cfg_refills, clk, rst_n, cfg_valid && cfg_ready, state_reg == ST_INIT)
    `BFA_ASSERT_IMPLY(a_eval_after_read, clk, rst_n, state_reg == ST_EVAL, $past(state_reg) == ST_READ)

endmodule

`default_nettype wire

FILE: hdl/bfa_datapath.sv
// ----------------------------------------------------------------------------
// bfa_datapath
// Bitmap memory, used count, request registers and per-word bit logic.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_frame_allocator_assert.svh"

module bfa_datapath
    import bfa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output stat_t                   st,
    input  wire req_t               in_word,
    input  wire logic [COUNT_W-1:0] cfg_data,
    output rsp_t                    out_word
);

    localparam logic [COUNT_W-1:0] TOTAL_MAX = COUNT_W'(MAX_FRAMES);
    localparam word_t              ONES      = '1;

    // bitmap memory
    word_t mem [WORD_COUNT];
    word_t rdata_reg;

    // control state
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] used_reg, used_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;

    // request and result registers
    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [FRAME_W-1:0] start_reg, start_next;
    logic [COUNT_W-1:0] end_reg, end_next;
    logic               first_reg, first_next;
    logic               kind_reg, kind_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic               granted_reg, granted_next;
    logic [COUNT_W-1:0] run_end_reg, run_end_next;
    logic               run_taken_reg, run_taken_next;
    rsp_t               out_reg, out_next;

    // memory write port
    logic  we;
    word_t wdata;

    // request decode
    logic [COUNT_W:0]   range_sum;
    logic [COUNT_W-1:0] range_end;
    logic [COUNT_W-1:0] cfg_sat;

    // per-word signals
    logic [COUNT_W-1:0] end_m1;
    logic [ADDR_W-1:0]  last_word;
    logic [BIT_W-1:0]   start_off;
    logic [BIT_W-1:0]   end_off;
    logic               at_last;
    logic [BIT_W-1:0]   free_pos;
    logic [FRAME_W-1:0] alloc_frame;
    logic               alloc_ok;
    word_t              lo_mask;
    word_t              hi_mask;
    word_t              range_mask;
    word_t              range_chg;
    logic [CNT_W-1:0]   range_cnt;
    logic               kind;
    word_t              run_diff;
    logic               run_hit;
    logic [COUNT_W-1:0] run_stop;

    // register sizes and word positions
    assign cfg_sat   = (cfg_data > TOTAL_MAX) ? TOTAL_MAX : cfg_data;
    assign range_sum = {1'b0, COUNT_W'(in_word.base_frame)} + {1'b0, in_word.frame_count};
    assign range_end = (range_sum > {1'b0, total_reg}) ? total_reg : range_sum[COUNT_W-1:0];
    assign end_m1    = end_reg - COUNT_W'(1);
    assign last_word = end_m1[BIT_W +: ADDR_W];
    assign end_off   = end_m1[BIT_W-1:0];
    assign start_off = start_reg[BIT_W-1:0];
    assign at_last   = (idx_reg == last_word);

    // allocate: lowest clear bit of the word
    assign free_pos    = lowest_one(~rdata_reg);
    assign alloc_frame = {idx_reg, free_pos};
    assign alloc_ok    = (rdata_reg != ONES) && ({1'b0, alloc_frame} < total_reg);

    // range: bits of this word inside the range
    assign lo_mask    = first_reg ? (ONES << start_off) : ONES;
    assign hi_mask    = at_last ? (ONES >> (BIT_W'(WORD_BITS - 1) - end_off)) : ONES;
    assign range_mask = lo_mask & hi_mask;
    assign range_chg  = (func_reg == FN_RESERVE) ? (range_mask & ~rdata_reg)
                                                 : (range_mask & rdata_reg);
    assign range_cnt  = count_ones(range_chg);

    // report: first bit differing from the run kind
    assign kind     = first_reg ? rdata_reg[start_off] : kind_reg;
    assign run_diff = (rdata_reg ^ {WORD_BITS{kind}}) & (first_reg ? (ONES << start_off) : ONES);
    assign run_hit  = (run_diff != '0);
    assign run_stop = {1'b0, idx_reg, lowest_one(run_diff)};

    // status to the controller
    always_comb
    begin
        st.fill_last = (idx_reg == ADDR_W'(WORD_COUNT - 1));
        st.at_last   = at_last;
        st.func      = func_reg;
        st.hit       = 1'b0;
        case (func_reg)
            FN_ALLOC:   st.hit = (rdata_reg != ONES);
            FN_REPORT:  st.hit = run_hit;
            default:    st.hit = 1'b0;
        endcase
        case (func_reg)
            FN_ALLOC:   st.no_work = (end_reg == '0);
            FN_FREE,
            FN_RESERVE,
            FN_RELEASE,
            FN_REPORT:  st.no_work = ({1'b0, start_reg} >= end_reg);
            default:    st.no_work = 1'b1;
        endcase
    end

    // next values
    always_comb
    begin
        total_next     = total_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        func_next      = func_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        first_next     = first_reg;
        kind_next      = kind_reg;
        frame_next     = frame_reg;
        granted_next   = granted_reg;
        run_end_next   = run_end_reg;
        run_taken_next = run_taken_reg;
        out_next       = out_reg;
        we             = 1'b0;
        wdata          = ONES;

        // configuration write restarts the fill
        if (cmd.cfg_load)
        begin
            total_next = cfg_sat;
            used_next  = cfg_sat;
            idx_next   = '0;
        end

        // fill sweep
        if (cmd.fill)
        begin
            we       = 1'b1;
            wdata    = ONES;
            idx_next = idx_reg + ADDR_W'(1);
        end

        // request capture
        if (cmd.load_req)
        begin
            func_next      = in_word.func;
            start_next     = in_word.base_frame;
            first_next     = 1'b1;
            frame_next     = '0;
            granted_next   = 1'b0;
            run_end_next   = COUNT_W'(in_word.base_frame);
            run_taken_next = 1'b0;
            if (in_word.func == FN_RESERVE || in_word.func == FN_RELEASE)
            begin
                end_next = range_end;
            end
            else
            begin
                end_next = total_reg;
            end
            if (in_word.func == FN_ALLOC)
            begin
                idx_next = '0;
            end
            else
            begin
                idx_next = in_word.base_frame[BIT_W +: ADDR_W];
            end
        end

        // next word of a scan
        if (cmd.step)
        begin
            idx_next = idx_reg + ADDR_W'(1);
        end

        // word update
        if (cmd.eval)
        begin
            first_next = 1'b0;
            case (func_reg)
                FN_ALLOC:
                begin
                    if (alloc_ok)
                    begin
                        we           = 1'b1;
                        wdata        = rdata_reg | (word_t'(1) << free_pos);
                        used_next    = used_reg + COUNT_W'(1);
                        frame_next   = alloc_frame;
                        granted_next = 1'b1;
                    end
                end
                FN_FREE:
                begin
                    if (rdata_reg[start_off])
                    begin
                        we        = 1'b1;
                        wdata     = rdata_reg & ~(word_t'(1) << start_off);
                        used_next = used_reg - COUNT_W'(1);
                    end
                end
                FN_RESERVE:
                begin
                    we        = 1'b1;
                    wdata     = rdata_reg | range_mask;
                    used_next = used_reg + COUNT_W'(range_cnt);
                end
                FN_RELEASE:
                begin
                    we        = 1'b1;
                    wdata     = rdata_reg & ~range_mask;
                    used_next = used_reg - COUNT_W'(range_cnt);
                end
                FN_REPORT:
                begin
                    kind_next      = kind;
                    run_taken_next = kind;
                    if (run_hit)
                    begin
                        run_end_next = (run_stop < total_reg) ? run_stop : total_reg;
                    end
                    else if (at_last)
                    begin
                        run_end_next = total_reg;
                    end
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end

        // result word
        if (cmd.load_out)
        begin
            out_next.frame_number = frame_reg;
            out_next.granted      = granted_reg;
            out_next.free_count   = total_reg - used_reg;
            out_next.run_length   = run_end_reg - COUNT_W'(start_reg);
            out_next.run_taken    = run_taken_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_MAX;
            used_reg  <= TOTAL_MAX;
            idx_reg   <= '0;
        end
        else
        begin
            total_reg <= total_next;
            used_reg  <= used_next;
            idx_reg   <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        start_reg     <= start_next;
        end_reg       <= end_next;
        first_reg     <= first_next;
        kind_reg      <= kind_next;
        frame_reg     <= frame_next;
        granted_reg   <= granted_next;
        run_end_reg   <= run_end_next;
        run_taken_reg <= run_taken_next;
        out_reg       <= out_next;
    end

    // bitmap memory, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[idx_reg] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[idx_reg];
        end
    end

    assign out_word = out_reg;

    `BFA_ASSERT_IMPLY(a_used_in_total, clk, rst_n, 1'b1, used_reg <= total_reg)
    `BFA_ASSERT_NEXT(a_used_quiet, clk, rst_n, !(cmd.eval || cmd.cfg_load), $stable(used_reg))
    `BFA_ASSERT_IMPLY(a_write_in_pass, clk, rst_n, we, cmd.fill || cmd.eval)

endmodule

`default_nettype wire

FILE: hdl/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit page frame allocator over a used-bit bitmap of 32-bit words.
// ----------------------------------------------------------------------------
//  channel  handshake               word
//  in       in_valid / in_stall     req_t: func, base_frame, frame_count
//  out      out_valid / out_stall   rsp_t: frame_number, granted, free_count,
//                                          run_length, run_taken
//  cfg      cfg_valid / cfg_ready   cfg_data: frames_managed
//
//  a request holds the block through READ and EVAL per word (read, then update)
//  and FINISH; with no word to read (past the total, empty range) READ goes to
//  FINISH. allocate reads up to the first non-full word, free one word, report
//  up to the end of the run, reserve and release the whole clipped range
//  after reset and each cfg write the bitmap fills with ones, one word a cycle
//  unless cfg_valid, no request taken; a stalled output holds only the finish
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_frame_allocator
    import bfa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire req_t               in_word,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output rsp_t                    out_word,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [COUNT_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t st;

    // sequencer
    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // bitmap and arithmetic
    bfa_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .in_word  (in_word),
        .cfg_data (cfg_data),
        .out_word (out_word)
    );

endmodule

`default_nettype wire
